@@ rtl/normalized_value_histogram_top_macros.svh @@
// Assertion macros shared by the histogram checker.
`ifndef NORMALIZED_VALUE_HISTOGRAM_TOP_MACROS_SVH
`define NORMALIZED_VALUE_HISTOGRAM_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define NVH_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("histogram check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define NVH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("histogram check failed");

`endif

@@ rtl/nvh_pkg.sv @@
// Shared sizes and constants of the normalized value histogram.
package nvh_pkg;

    localparam int BINS      = 64;
    localparam int FRAC_BITS = 16;

    localparam int VALUE_W = 6;
    localparam int IDX_W   = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int CNT_W   = 16;
    localparam int SHARE_W = 17;
    localparam int QUOT_W  = CNT_W + FRAC_BITS;
    localparam int STEP_W  = $clog2(QUOT_W + 1);

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

endpackage

@@ rtl/nvh_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module nvh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/nvh_div.sv @@
// Restoring divider that forms floor(count * 2^FRAC_BITS / total), one bit per cycle.
module nvh_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [nvh_pkg::CNT_W-1:0]     dividend,
    input  logic [nvh_pkg::CNT_W-1:0]     divisor,
    output logic                          done,
    output logic [nvh_pkg::SHARE_W-1:0]   quot
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [nvh_pkg::STEP_W-1:0]    step_reg;
    logic [nvh_pkg::QUOT_W-1:0]    num_reg;
    logic [nvh_pkg::CNT_W-1:0]     rem_reg;
    logic [nvh_pkg::CNT_W-1:0]     div_reg;
    logic [nvh_pkg::SHARE_W-1:0]   q_reg;
    logic                          zero_reg;

    logic [nvh_pkg::CNT_W:0]       trial;
    logic [nvh_pkg::CNT_W:0]       diff;
    logic                          ge;

    assign trial = {rem_reg, num_reg[nvh_pkg::QUOT_W-1]};
    assign ge    = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= nvh_pkg::STEP_W'(nvh_pkg::QUOT_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == nvh_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= {dividend, {nvh_pkg::FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            div_reg  <= divisor;
            q_reg    <= '0;
            zero_reg <= (divisor == '0);
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[nvh_pkg::QUOT_W-2:0], 1'b0};
            rem_reg <= ge ? diff[nvh_pkg::CNT_W-1:0] : trial[nvh_pkg::CNT_W-1:0];
            // Quotient bits above the share width fall off the top.
            q_reg   <= {q_reg[nvh_pkg::SHARE_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = zero_reg ? '0 : q_reg;

endmodule

@@ rtl/normalized_value_histogram_top.sv @@
// Top level of the normalized value histogram: bin counting and normalized emission.
//
// The block counts small unsigned values into BINS bins held in a RAM, keeps the
// total and the largest value in registers, and on the item marked last emits one
// transfer per bin from bin 0 up to the largest value, each with the bin count and
// its share floor(count * 2^16 / total). Ordinary items are taken one per cycle:
// a two-stage read-modify-write on the bin RAM, with the last written entry
// forwarded so that back-to-back hits on the same bin count correctly. After the
// last item the input is stalled for the emission: a drain state, then for each
// emitted bin the read, data, divide and output states, the divide state waiting
// on the bit-serial divider that forms each share, and the output state on a
// stalled output. The final bin's transfer may still wait at the output while
// the next set is being loaded. Values of BINS or more go to the top
// bin; counts and the total saturate at 65535. A valid bit per bin stands for the
// cleared RAM, so reset and the end of each set clear every bin at once.
module normalized_value_histogram_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [nvh_pkg::VALUE_W-1:0]   value,
    input  logic                          last_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [nvh_pkg::IDX_W-1:0]     bin_index,
    output logic [nvh_pkg::CNT_W-1:0]     bin_count,
    output logic [nvh_pkg::SHARE_W-1:0]   share,
    output logic                          last_bin
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_DRAIN,
        S_READ,
        S_DATA,
        S_DIV,
        S_OUT
    } state_t;

    state_t                          state_reg;

    // Stage one of the read-modify-write and the forwarding register.
    logic                            s1_valid_reg;
    logic [nvh_pkg::IDX_W-1:0]       s1_idx_reg;
    logic                            fwd_valid_reg;
    logic [nvh_pkg::IDX_W-1:0]       fwd_addr_reg;
    logic [nvh_pkg::CNT_W-1:0]       fwd_data_reg;

    logic [nvh_pkg::CNT_W-1:0]       total_reg;
    logic [nvh_pkg::IDX_W-1:0]       largest_reg;
    logic [nvh_pkg::BINS-1:0]        bin_valid_reg;
    logic [nvh_pkg::IDX_W-1:0]       bin_reg;
    logic [nvh_pkg::CNT_W-1:0]       cnt_reg;

    logic                            out_valid_reg;
    logic [nvh_pkg::IDX_W-1:0]       bin_index_reg;
    logic [nvh_pkg::CNT_W-1:0]       bin_count_reg;
    logic [nvh_pkg::SHARE_W-1:0]     share_reg;
    logic                            last_bin_reg;

    logic                            in_xfer;
    logic                            out_free;
    logic [nvh_pkg::IDX_W-1:0]       in_idx;
    logic [nvh_pkg::IDX_W-1:0]       rd_addr;
    logic [nvh_pkg::CNT_W-1:0]       rd_data;
    logic [nvh_pkg::CNT_W-1:0]       old_cnt;
    logic [nvh_pkg::CNT_W-1:0]       new_cnt;
    logic [nvh_pkg::CNT_W-1:0]       emit_cnt;
    logic                            div_start;
    logic                            div_done;
    logic [nvh_pkg::SHARE_W-1:0]     div_quot;

    assign in_stall = (state_reg != S_LOAD);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Values beyond the last bin are folded into it.
    assign in_idx = (int'(value) >= nvh_pkg::BINS) ? nvh_pkg::IDX_W'(nvh_pkg::BINS - 1)
                                                    : nvh_pkg::IDX_W'(value);

    assign rd_addr = (state_reg == S_LOAD) ? in_idx : bin_reg;

    // The RAM returns stale data when the entry was written in the previous cycle,
    // so that write is forwarded. A bin with its valid bit clear reads as zero.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_idx_reg))
        begin
            old_cnt = fwd_data_reg;
        end
        else if (bin_valid_reg[s1_idx_reg])
        begin
            old_cnt = rd_data;
        end
        else
        begin
            old_cnt = '0;
        end
    end

    assign new_cnt   = (old_cnt == nvh_pkg::COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
    assign emit_cnt  = bin_valid_reg[bin_reg] ? rd_data : '0;
    assign div_start = (state_reg == S_DATA);

    nvh_ram #(
        .WIDTH (nvh_pkg::CNT_W),
        .DEPTH (nvh_pkg::BINS)
    ) u_bins (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_idx_reg),
        .wr_data (new_cnt),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The divider takes the bin count straight from the RAM read in the cycle
    // that it starts.
    nvh_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (emit_cnt),
        .divisor  (total_reg),
        .done     (div_done),
        .quot     (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            total_reg     <= '0;
            largest_reg   <= '0;
            bin_valid_reg <= '0;
            bin_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_xfer;
            fwd_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                bin_valid_reg[s1_idx_reg] <= 1'b1;
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_xfer)
                    begin
                        if (total_reg != nvh_pkg::COUNT_MAX)
                        begin
                            total_reg <= total_reg + 1'b1;
                        end
                        if (in_idx > largest_reg)
                        begin
                            largest_reg <= in_idx;
                        end
                        if (last_value)
                        begin
                            state_reg <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN:
                begin
                    // The last item writes its bin in this cycle.
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    state_reg <= S_DATA;
                end
                S_DATA:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (bin_reg == largest_reg)
                        begin
                            total_reg     <= '0;
                            largest_reg   <= '0;
                            bin_valid_reg <= '0;
                            bin_reg       <= '0;
                            state_reg     <= S_LOAD;
                        end
                        else
                        begin
                            bin_reg   <= bin_reg + 1'b1;
                            state_reg <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= in_idx;
        fwd_addr_reg <= s1_idx_reg;
        fwd_data_reg <= new_cnt;
        if (state_reg == S_READ)
        begin
            cnt_reg <= '0;
        end
        if (state_reg == S_DATA)
        begin
            cnt_reg <= emit_cnt;
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            bin_index_reg <= bin_reg;
            bin_count_reg <= cnt_reg;
            share_reg     <= div_quot;
            last_bin_reg  <= (bin_reg == largest_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign bin_index = bin_index_reg;
    assign bin_count = bin_count_reg;
    assign share     = share_reg;
    assign last_bin  = last_bin_reg;

endmodule

@@ rtl/nvh_checker.sv @@
// Port-level checker of the normalized value histogram and its bind statement.
`include "normalized_value_histogram_top_macros.svh"

module nvh_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [nvh_pkg::VALUE_W-1:0]   value,
    input  logic                          last_value,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [nvh_pkg::IDX_W-1:0]     bin_index,
    input  logic [nvh_pkg::CNT_W-1:0]     bin_count,
    input  logic [nvh_pkg::SHARE_W-1:0]   share,
    input  logic                          last_bin
);

    // A stalled result stays offered.
    `NVH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // A stalled result keeps its payload.
    `NVH_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(bin_index) && $stable(bin_count) && $stable(share) && $stable(last_bin))

    // While a distribution is still being emitted the input is held off.
    `NVH_ASSERT_IMPLY(a_in_held, out_valid && !last_bin, in_stall)

    // Bins of one distribution follow in ascending order.
    `NVH_ASSERT_NEXT(a_bin_order, out_valid && !out_stall && !last_bin, !out_valid || (bin_index == nvh_pkg::IDX_W'($past(bin_index) + 1'b1)))

    // An empty bin has a zero share.
    `NVH_ASSERT_IMPLY(a_empty_share, out_valid && (bin_count == '0), share == '0)

endmodule

bind normalized_value_histogram_top nvh_checker u_nvh_checker (.*);

@@ sim/nvh_bin_share_monitor.sv @@
// Monitor that predicts the histogram emission and compares every output transfer.
module nvh_bin_share_monitor
    import nvh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [VALUE_W-1:0]   value,
    input  logic                 last_value,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [IDX_W-1:0]     bin_index,
    input  logic [CNT_W-1:0]     bin_count,
    input  logic [SHARE_W-1:0]   share,
    input  logic                 last_bin,
    output int                   mismatch_count,
    output int                   bins_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic [CNT_W-1:0]   count;
        logic [SHARE_W-1:0] frac;
        logic               closes;
    } bin_result_t;

    logic [CNT_W-1:0] bin_tally [BINS];
    logic [CNT_W-1:0] set_total;
    int               peak_bin;
    bin_result_t      expected_bins [$];
    bin_result_t      want;
    int               mismatches;

    task automatic flag_mismatch(input string note);
        $display("histogram mismatch at %0t ns: %s", $time, note);
        mismatches++;
    endtask

    task automatic clear_set();
        foreach (bin_tally[i])
            bin_tally[i] = '0;
        set_total = '0;
        peak_bin  = 0;
    endtask

    // Counts one value; the closing value of a set queues one expected bin per
    // index from zero up to the largest bin hit.
    task automatic tally_value(input logic [VALUE_W-1:0] v, input logic closing);
        int               slot;
        longint unsigned  scaled;
        bin_result_t      r;
        slot = (v >= BINS) ? BINS - 1 : int'(v);
        if (bin_tally[slot] != COUNT_MAX)
            bin_tally[slot]++;
        if (set_total != COUNT_MAX)
            set_total++;
        if (slot > peak_bin)
            peak_bin = slot;
        if (closing)
        begin
            for (int b = 0; b <= peak_bin; b++)
            begin
                scaled   = 64'(bin_tally[b]) << FRAC_BITS;
                r.index  = IDX_W'(b);
                r.count  = bin_tally[b];
                r.frac   = SHARE_W'(scaled / 64'(set_total));
                r.closes = (b == peak_bin);
                expected_bins = {expected_bins, r};
            end
            clear_set();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_set();
            expected_bins.delete();
            mismatches = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_bins.size() == 0)
                    flag_mismatch($sformatf("bin %0d arrived with nothing expected", bin_index));
                else
                begin
                    want = expected_bins.pop_front();
                    if (bin_index !== want.index)
                        flag_mismatch($sformatf("bin_index %0d, expected %0d",
                                                bin_index, want.index));
                    if (bin_count !== want.count)
                        flag_mismatch($sformatf("bin %0d: bin_count %0d, expected %0d",
                                                want.index, bin_count, want.count));
                    if (share !== want.frac)
                        flag_mismatch($sformatf("bin %0d: share %0d, expected %0d",
                                                want.index, share, want.frac));
                    if (last_bin !== want.closes)
                        flag_mismatch($sformatf("bin %0d: last_bin %0b, expected %0b",
                                                want.index, last_bin, want.closes));
                end
            end
            if (in_valid && !in_stall)
                tally_value(value, last_value);
        end
        mismatch_count   <= mismatches;
        bins_outstanding <= expected_bins.size();
    end

endmodule

@@ sim/tb_normalized_value_histogram_top.sv @@
// Testbench top: stimulus, flow control and verdict for the normalized value histogram.
module tb_normalized_value_histogram_top;
    import nvh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Watchdog limit. The slowest correct run closes every set after a single
    // value of 63, so that each of at most 210 sets emits all 64 bins, plus the
    // output stalls; this limit lies well above the time that this takes.
    localparam int LIMIT_CYCLES  = 5_000_000;
    // Cycles the receiver holds off in the pressure phase; far longer than the
    // block needs to fill up and stall its input.
    localparam int HOLD_CYCLES   = 800;
    // Quiet cycles after the last expected bin, longer than one full emission
    // step, so that a stray extra transfer would still be seen.
    localparam int TAIL_CYCLES   = 200;
    localparam int RANDOM_ITEMS  = 200;

    // Flow-control phases shared by the sender and the receiver.
    typedef enum int {
        PACE_NONE,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH,
        PACE_HOLD
    } pace_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic [VALUE_W-1:0] value      = '0;
    logic               last_value = 1'b0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic [IDX_W-1:0]   bin_index;
    logic [CNT_W-1:0]   bin_count;
    logic [SHARE_W-1:0] share;
    logic               last_bin;

    int    mismatch_count;
    int    bins_outstanding;
    pace_t pace        = PACE_NONE;
    int    cycle_count = 0;
    int    hold_left   = 0;
    bit    hold_done   = 1'b0;
    int    items_sent  = 0;

    always #5 clk = ~clk;

    normalized_value_histogram_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .last_value (last_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bin_index  (bin_index),
        .bin_count  (bin_count),
        .share      (share),
        .last_bin   (last_bin)
    );

    nvh_bin_share_monitor i_monitor (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .value            (value),
        .last_value       (last_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .bin_index        (bin_index),
        .bin_count        (bin_count),
        .share            (share),
        .last_bin         (last_bin),
        .mismatch_count   (mismatch_count),
        .bins_outstanding (bins_outstanding)
    );

    // Offers one value and returns at the edge where the transfer takes place.
    // Idle cycles are inserted before the offer according to the current phase;
    // once valid is raised, the payload stays put until the block accepts it.
    // Each pass through a loop assigns in_valid at most once and then advances time, so
    // no signal gets two nonblocking assignments in one time step.
    task automatic offer_value(input logic [VALUE_W-1:0] v, input logic closing);
        while ((pace == PACE_SEND_IDLE && $urandom_range(99) < 83) ||
               (pace == PACE_BOTH && $urandom_range(99) < 25))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        value      <= v;
        last_value <= closing;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // Degrees cluster at small values in practice; most values are kept low so
    // that emissions stay short, with an occasional value anywhere in range so
    // that every bit of the field toggles and wide emissions still occur.
    function automatic logic [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return VALUE_W'($urandom_range(7));
        else if (roll < 90)
            return VALUE_W'($urandom_range(20));
        return VALUE_W'($urandom_range((1 << VALUE_W) - 1));
    endfunction

    // A set is any run of values closed by one marked last; every sequence is
    // well formed, so the random part is all sets of random length and content.
    task automatic send_random_set(input int len);
        for (int i = 0; i < len; i++)
            offer_value(pick_value(), i == len - 1);
    endtask

    // Receiver side. In the pressure phase the stall is held high for a counted
    // stretch once, so that a finished emission cannot drain and the block
    // backs up into its input while the sender keeps offering values.
    always @(posedge clk)
    begin
        if (pace == PACE_HOLD && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (pace == PACE_RECV_STALL)
            out_stall <= ($urandom_range(99) < 83);
        else if (pace == PACE_BOTH)
            out_stall <= ($urandom_range(99) < 25);
        else
            out_stall <= 1'b0;
    end

    // Watchdog: a hung handshake or an emission that never completes ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets, no idling on either side.
        // A lone value in bin zero: one bin whose share is the full 2^16.
        offer_value(6'd0, 1'b1);
        // A lone value at the top of the range: all 64 bins, 63 of them empty.
        offer_value(6'd63, 1'b1);
        // Alternating bit patterns, with back-to-back hits on one bin.
        offer_value(6'h2A, 1'b0);
        offer_value(6'h15, 1'b0);
        offer_value(6'h15, 1'b0);
        offer_value(6'h15, 1'b1);
        // The largest value comes first, so the closing value is not the peak.
        offer_value(6'd40, 1'b0);
        offer_value(6'd3, 1'b0);
        offer_value(6'd3, 1'b0);
        offer_value(6'd3, 1'b1);
        // A run of identical values exercises the read-modify-write forwarding.
        repeat (5) offer_value(6'd5, 1'b0);
        offer_value(6'd5, 1'b1);
        // Short sets straight after one another, the first bin of one set
        // entering while the final bin of the previous one may still wait.
        offer_value(6'd1, 1'b0);
        offer_value(6'd2, 1'b1);
        offer_value(6'd0, 1'b1);

        // Random sets, moving through the flow-control phases every 50 or so
        // transfers so that gaps land on loading, draining and emission alike.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            pace = pace_t'((items_sent / 50) % 4);
            send_random_set($urandom_range(1, 10));
        end

        // Pressure: the receiver holds off while several sets are offered back
        // to back, so the block has to stall its input.
        pace = PACE_HOLD;
        repeat (3) send_random_set($urandom_range(4, 8));
        pace = PACE_NONE;

        in_valid <= 1'b0;
        @(posedge clk);

        // Drain every expected bin, then give stray transfers a chance to show.
        while (bins_outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && bins_outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
